### hdl/lbd3_pkg.sv
// ----------------------------------------------------------------------------
// lbd3_pkg
// shared widths, register indexes and mask bit positions of the 3x3 label
// boundary detector
// ----------------------------------------------------------------------------
package lbd3_pkg;

  // field widths
  localparam int unsigned LABEL_W        = 8;
  localparam int unsigned ROW_W          = 12;
  localparam int unsigned COL_W          = 11;
  localparam int unsigned MASK_W         = 8;
  localparam int unsigned FRAME_WIDTH_W  = 12;
  localparam int unsigned FRAME_HEIGHT_W = 13;

  // stream word widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 13;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } lbd3_cfg_idx_e;

  // neighbour mask bit positions
  localparam int unsigned NB_UP_LEFT    = 7;
  localparam int unsigned NB_UP         = 6;
  localparam int unsigned NB_UP_RIGHT   = 5;
  localparam int unsigned NB_RIGHT      = 4;
  localparam int unsigned NB_DOWN_RIGHT = 3;
  localparam int unsigned NB_DOWN       = 2;
  localparam int unsigned NB_DOWN_LEFT  = 1;
  localparam int unsigned NB_LEFT       = 0;

  // one column of labels entering the window, top row first
  typedef struct packed {
    logic [LABEL_W-1:0] top;
    logic [LABEL_W-1:0] mid;
    logic [LABEL_W-1:0] bot;
  } lbd3_column_t;

endpackage

### hdl/lbd3_window.sv
// ----------------------------------------------------------------------------
// lbd3_window
// 3x3 label window: keeps the two most recent columns and compares all
// eight neighbours of the centre against it as a new column arrives
// ----------------------------------------------------------------------------
module lbd3_window
  import lbd3_pkg::*;
(
  input  logic                clk_i,
  input  logic                shift_i,
  input  lbd3_column_t        col_i,
  output logic [MASK_W-1:0]   mask_o,
  output logic                boundary_o
);

  // these hold the left and centre columns; col_i is the right column
  logic [LABEL_W-1:0] up_l_q, up_c_q;
  logic [LABEL_W-1:0] md_l_q, md_c_q;
  logic [LABEL_W-1:0] dn_l_q, dn_c_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      up_l_q <= up_c_q;
      md_l_q <= md_c_q;
      dn_l_q <= dn_c_q;
      up_c_q <= col_i.top;
      md_c_q <= col_i.mid;
      dn_c_q <= col_i.bot;
    end
  end

  always_comb begin
    mask_o                = '0;
    mask_o[NB_UP_LEFT]    = (up_l_q    != md_c_q);
    mask_o[NB_UP]         = (up_c_q    != md_c_q);
    mask_o[NB_UP_RIGHT]   = (col_i.top != md_c_q);
    mask_o[NB_RIGHT]      = (col_i.mid != md_c_q);
    mask_o[NB_DOWN_RIGHT] = (col_i.bot != md_c_q);
    mask_o[NB_DOWN]       = (dn_c_q    != md_c_q);
    mask_o[NB_DOWN_LEFT]  = (dn_l_q    != md_c_q);
    mask_o[NB_LEFT]       = (md_l_q    != md_c_q);
  end

  // two or more bits set: clearing the lowest set bit leaves something
  assign boundary_o = (mask_o != '0) && ((mask_o & (mask_o - MASK_W'(1))) != '0);

endmodule

### hdl/label_boundary_detector_3x3.sv
// ----------------------------------------------------------------------------
// label_boundary_detector_3x3
// marks boundary pixels of a segmentation label image with a 3x3 window
// ----------------------------------------------------------------------------
// usage
//   slave stream: one 8-bit label per word in raster order, tuser marks the
//   first pixel of a frame and restarts the row and column counters
//   master stream: one word per interior pixel (row, col, neighbour mask,
//   boundary flag), tlast on the last interior pixel of the frame; border
//   rows and columns produce no word
//   cfg port: frame width (index 0) and frame height (index 1), clamped to
//   the supported range on write; write only while the stream is idle
// latency: a judged pixel leaves two cycles after the label that completes
//   its window is accepted (line store read, then output register)
// throughput: one label per cycle; the line stores take one read and one
//   write-back per cycle, back-to-back words to the same column are
//   forwarded around the memory
// reset: counters restart at (0,0), frame size 640 x 480, no word pending;
//   line store contents are not cleared (rows 0 and 1 never emit)
// stall: when m_axis_tready_i is low the output word holds and the input
//   keeps taking labels until the one stage between them is full
// ----------------------------------------------------------------------------
module label_boundary_detector_3x3
  import lbd3_pkg::*;
#(
  parameter int unsigned MAX_LINE_WIDTH = 2048
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // slave stream
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]     s_axis_tdata_i,   // [7:0] label
  input  logic                      s_axis_tuser_i,   // [0] frame_start
  // master stream
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // [11:0] row, [22:12] col, [30:23] neighbour_mask, [31] is_boundary
  output logic [OUT_TDATA_W-1:0]    m_axis_tdata_o,
  output logic                      m_axis_tlast_o,   // frame_last
  // configuration write port
  input  logic                      cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned AW      = $clog2(MAX_LINE_WIDTH);
  // widest supported row: the line store depth, capped at what the 12-bit width register can ask for
  localparam int unsigned W_LIMIT = (MAX_LINE_WIDTH > 4095) ? 4095 : MAX_LINE_WIDTH;
  localparam logic [FRAME_WIDTH_W-1:0] W_MAX_M1 = FRAME_WIDTH_W'(W_LIMIT - 1);
  localparam logic [FRAME_WIDTH_W-1:0] W_RST_M1 =
    FRAME_WIDTH_W'((W_LIMIT < 640) ? (W_LIMIT - 1) : 639);
  localparam logic [ROW_W-1:0] H_RST_M1 = ROW_W'(479);
  localparam logic [ROW_W-1:0] H_MAX_M1 = ROW_W'(4095);

  // -------------------------------------------------------------------------
  // frame geometry, stored as last column / last row index
  // -------------------------------------------------------------------------
  logic [FRAME_WIDTH_W-1:0] w_last_q, w_last_d;
  logic [ROW_W-1:0]         h_last_q, h_last_d;
  logic [FRAME_WIDTH_W-1:0] cfg_w;

  assign cfg_w = cfg_wdata_i[FRAME_WIDTH_W-1:0];

  always_comb begin
    w_last_d = w_last_q;
    h_last_d = h_last_q;
    if (cfg_we_i) begin
      unique case (lbd3_cfg_idx_e'(cfg_addr_i))
        CFG_FRAME_WIDTH: begin
          if (cfg_w < FRAME_WIDTH_W'(3)) begin
            w_last_d = FRAME_WIDTH_W'(2);
          end else if ((cfg_w - FRAME_WIDTH_W'(1)) > W_MAX_M1) begin
            w_last_d = W_MAX_M1;
          end else begin
            w_last_d = cfg_w - FRAME_WIDTH_W'(1);
          end
        end
        CFG_FRAME_HEIGHT: begin
          if (cfg_wdata_i < CFG_DATA_W'(3)) begin
            h_last_d = ROW_W'(2);
          end else if (cfg_wdata_i > CFG_DATA_W'(4096)) begin
            h_last_d = H_MAX_M1;
          end else begin
            h_last_d = ROW_W'(cfg_wdata_i - CFG_DATA_W'(1));
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q <= W_RST_M1;
      h_last_q <= H_RST_M1;
    end else begin
      w_last_q <= w_last_d;
      h_last_q <= h_last_d;
    end
  end

  // -------------------------------------------------------------------------
  // handshake
  // -------------------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic s1_adv;    // stage 1 may hand its pixel on
  logic s1_fire;   // stage 1 retires a pixel this cycle
  logic in_fire;

  assign s1_adv          = !out_valid_q || m_axis_tready_i;
  assign s1_fire         = s1_valid_q && s1_adv;
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // -------------------------------------------------------------------------
  // raster counters (stage 0)
  // -------------------------------------------------------------------------
  logic [FRAME_WIDTH_W-1:0] col_q, col_d;
  logic [ROW_W-1:0]         row_q, row_d;
  logic [FRAME_WIDTH_W-1:0] c_raw, c_cur;
  logic [ROW_W-1:0]         r_raw, r_cur;
  logic                     cur_emit, cur_last;
  logic [AW-1:0]            rd_addr;

  always_comb begin
    c_raw = s_axis_tuser_i ? '0 : col_q;
    r_raw = s_axis_tuser_i ? '0 : row_q;
    // a counter past the end of its row or frame sits on the last index
    c_cur = (c_raw > w_last_q) ? w_last_q : c_raw;
    r_cur = (r_raw > h_last_q) ? h_last_q : r_raw;

    if (c_cur >= w_last_q) begin
      col_d = '0;
      row_d = (r_cur >= h_last_q) ? '0 : r_cur + ROW_W'(1);
    end else begin
      col_d = c_cur + FRAME_WIDTH_W'(1);
      row_d = r_cur;
    end

    cur_emit = (r_cur >= ROW_W'(2)) && (c_cur >= FRAME_WIDTH_W'(2));
    cur_last = (r_cur == h_last_q) && (c_cur == w_last_q);
    rd_addr  = AW'(c_cur);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // -------------------------------------------------------------------------
  // stage 1: line store read data arrives, write-back, window update
  // -------------------------------------------------------------------------
  logic [LABEL_W-1:0] s1_label_q;
  logic [AW-1:0]      s1_addr_q;
  logic               s1_emit_q, s1_last_q;
  logic [ROW_W-1:0]   s1_row_q;
  logic [COL_W-1:0]   s1_col_q;
  logic               fwd_q, fwd_d;
  logic [LABEL_W-1:0] fwd_prev_q, fwd_older_q;
  logic [LABEL_W-1:0] prev_rd_q, older_rd_q;
  logic [LABEL_W-1:0] prev_eff, older_eff;

  // same column written back and read at one edge: take the write data
  assign fwd_d     = s1_fire && (s1_addr_q == rd_addr);
  assign prev_eff  = fwd_q ? fwd_prev_q  : prev_rd_q;
  assign older_eff = fwd_q ? fwd_older_q : older_rd_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_label_q  <= s_axis_tdata_i[LABEL_W-1:0];
      s1_addr_q   <= rd_addr;
      s1_emit_q   <= cur_emit;
      s1_last_q   <= cur_last;
      s1_row_q    <= r_cur - ROW_W'(1);
      s1_col_q    <= COL_W'(c_cur - FRAME_WIDTH_W'(1));
      fwd_q       <= fwd_d;
      fwd_prev_q  <= s1_label_q;
      fwd_older_q <= prev_eff;
    end
  end

  // line stores: row above and row two above
  logic [LABEL_W-1:0] prev_mem  [MAX_LINE_WIDTH];
  logic [LABEL_W-1:0] older_mem [MAX_LINE_WIDTH];

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      prev_rd_q  <= prev_mem[rd_addr];
      older_rd_q <= older_mem[rd_addr];
    end
    if (s1_fire) begin
      prev_mem[s1_addr_q]  <= s1_label_q;
      older_mem[s1_addr_q] <= prev_eff;
    end
  end

  lbd3_column_t      new_col;
  logic [MASK_W-1:0] mask;
  logic              boundary;

  assign new_col.top = older_eff;
  assign new_col.mid = prev_eff;
  assign new_col.bot = s1_label_q;

  lbd3_window u_window (
    .clk_i      (clk_i),
    .shift_i    (s1_fire),
    .col_i      (new_col),
    .mask_o     (mask),
    .boundary_o (boundary)
  );

  // -------------------------------------------------------------------------
  // output register
  // -------------------------------------------------------------------------
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                   out_last_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = s1_emit_q;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_data_q <= {boundary, mask, s1_col_q, s1_row_q};
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

### hdl/lbd3_checker.sv
// ----------------------------------------------------------------------------
// lbd3_checker
// port-level checks of the 3x3 label boundary detector
// ----------------------------------------------------------------------------
module lbd3_checker
  import lbd3_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                   m_axis_tlast_o
);

  // held output word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  // boundary flag agrees with the mask
  a_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[31] == ($countones(m_axis_tdata_o[30:23]) >= 2)))
    else $error("boundary flag disagrees with neighbour mask");

  // judged pixels never lie in row zero
  a_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[11:0] != 12'd0))
    else $error("border row emitted");

  // input only backs off behind a stalled output word
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without a held output word");

  // nothing pending during reset
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

endmodule

bind label_boundary_detector_3x3 lbd3_checker u_lbd3_checker (.*);

### verif/label_boundary_detector_3x3_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// label_boundary_detector_3x3_test
// self-checking bench for the 3x3 label boundary detector: a cycle-free
// predictor of the window logic computes the verdict of every interior pixel
// and each output word is checked field by field against it, under random
// input gaps, output stalls and frame sizes from 3x3 upward, with
// out-of-range sizes clamped
// ----------------------------------------------------------------------------
module label_boundary_detector_3x3_test;
  import lbd3_pkg::*;

  localparam int unsigned LINE_MAX      = 2048;  // line store depth of the instance
  localparam int unsigned HEIGHT_MAX    = 4096;
  localparam int unsigned RANDOM_ITEMS  = 500;
  localparam int unsigned SETTLE_CYCLES = 8;     // margin for the pipeline to drain
  localparam int unsigned HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int unsigned STALL_LIMIT   = 2000;  // cycles without any word moving
  localparam int unsigned MAX_REPORTS   = 30;

  // four 3x3 frames of extreme labels, first pixel in the top byte:
  // uniform, centre differs from all, one neighbour differs, two differ
  localparam logic [4*72-1:0] EXTREME_LABELS = {
    72'hFFFFFFFFFFFFFFFFFF,
    72'hFFFFFFFF00FFFFFFFF,
    72'h0000000000FF000000,
    72'h00AA00000000550000
  };

  typedef enum int unsigned {
    READY_ALWAYS,
    READY_PATTERN,
    READY_RANDOM
  } ready_mode_e;

  typedef enum int unsigned {
    LABELS_RUNS,
    LABELS_RANDOM,
    LABELS_BLOCKS
  } label_style_e;

  // one verdict on an interior pixel
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [MASK_W-1:0] mask;
    logic              boundary;
    logic              frame_last;
  } pixel_verdict_t;

  // clock, reset and block ports
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_TDATA_W-1:0] s_axis_tdata_i;
  logic                  s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tlast_o;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // predictor state: registers, line stores, window and raster counters
  logic [FRAME_WIDTH_W-1:0]  width_reg;
  logic [FRAME_HEIGHT_W-1:0] height_reg;
  logic [LABEL_W-1:0]        row_above [LINE_MAX];
  logic [LABEL_W-1:0]        row_above2 [LINE_MAX];
  logic [LABEL_W-1:0]        window [3][3];  // [up, mid, down][left, centre, right]
  int unsigned               col_pos;
  int unsigned               row_pos;

  // verdicts waiting for their output word
  pixel_verdict_t verdict_q[$];
  pixel_verdict_t want_v;
  pixel_verdict_t got_v;

  // sender and receiver controls
  int unsigned    burst_left;
  bit             gaps_on;
  bit             restart_needed;   // width grew: next word must open a frame
  ready_mode_e    ready_mode;
  logic [15:0]    ready_pattern;
  int unsigned    ready_phase;
  int unsigned    hold_req;
  label_style_e   label_style;
  logic [LABEL_W-1:0] palette [3];
  logic [LABEL_W-1:0] last_label;

  // bookkeeping
  int unsigned labels_sent;
  int unsigned verdicts_checked;
  int unsigned frames_closed;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  label_boundary_detector_3x3 #(
    .MAX_LINE_WIDTH (LINE_MAX)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // frame size as the block uses it, clamped to the supported range
  function automatic int unsigned eff_width();
    int unsigned w;
    w = 32'(width_reg);
    if (w < 3) w = 3;
    if (w > LINE_MAX) w = LINE_MAX;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = 32'(height_reg);
    if (h < 3) h = 3;
    if (h > HEIGHT_MAX) h = HEIGHT_MAX;
    return h;
  endfunction

  // advance the window by one label; returns 1 when an interior pixel is judged
  function automatic bit judge_pixel(input logic [LABEL_W-1:0] lab, input logic fs,
                                     output pixel_verdict_t v);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int k;
    logic [LABEL_W-1:0] ctr;
    logic [MASK_W-1:0] m;
    bit judged;
    w = eff_width();
    h = eff_height();
    judged = 1'b0;
    v = '0;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    // counters past a shrunk size behave as if at the end
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    for (k = 0; k < 3; k++) begin
      window[k][0] = window[k][1];
      window[k][1] = window[k][2];
    end
    window[0][2] = row_above2[c];
    window[1][2] = row_above[c];
    row_above2[c] = row_above[c];
    row_above[c] = lab;
    window[2][2] = lab;
    if (r >= 2 && c >= 2) begin
      ctr = window[1][1];
      m = '0;
      m[NB_UP_LEFT]    = (window[0][0] != ctr);
      m[NB_UP]         = (window[0][1] != ctr);
      m[NB_UP_RIGHT]   = (window[0][2] != ctr);
      m[NB_RIGHT]      = (window[1][2] != ctr);
      m[NB_DOWN_RIGHT] = (window[2][2] != ctr);
      m[NB_DOWN]       = (window[2][1] != ctr);
      m[NB_DOWN_LEFT]  = (window[2][0] != ctr);
      m[NB_LEFT]       = (window[1][0] != ctr);
      v.row        = ROW_W'(r - 1);
      v.col        = COL_W'(c - 1);
      v.mask       = m;
      v.boundary   = ($countones(m) >= 2);
      v.frame_last = (r == h - 1) && (c == w - 1);
      judged = 1'b1;
    end
    // raster counters wrap at the end of a row and of a frame
    if (c >= w - 1) begin
      col_pos = 0;
      row_pos = (r >= h - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
    return judged;
  endfunction

  // label source: horizontal runs, full random, or blocky regions
  function automatic logic [LABEL_W-1:0] next_label();
    logic [LABEL_W-1:0] lab;
    case (label_style)
      LABELS_RANDOM: lab = LABEL_W'($urandom);
      LABELS_BLOCKS: lab = palette[((col_pos >> 2) + (row_pos >> 2)) % 3];
      default: begin
        if ($urandom_range(0, 9) < 6) lab = last_label;
        else lab = palette[$urandom_range(0, 2)];
      end
    endcase
    last_label = lab;
    return lab;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one label word, in bursts with random gaps, and predict its verdict
  task automatic send_pixel(input logic [LABEL_W-1:0] lab, input logic fs);
    int unsigned gap;
    pixel_verdict_t v;
    if (burst_left == 0) begin
      gap = 0;
      if (gaps_on) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
      end
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    // line store columns past the old width were never written in this frame
    if (restart_needed) begin
      fs = 1'b1;
      restart_needed = 1'b0;
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= lab;
    s_axis_tuser_i  <= fs;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (judge_pixel(lab, fs, v)) verdict_q = {verdict_q, v};
    labels_sent++;
  endtask

  // n labels; optional frame start on the first, random restarts after it
  task automatic send_run(input int unsigned n, input logic first_fs,
                          input int unsigned restart_permille);
    int unsigned i;
    logic fs;
    for (i = 0; i < n; i++) begin
      fs = (i == 0) ? first_fs : ($urandom_range(0, 999) < restart_permille);
      send_pixel(next_label(), fs);
    end
  endtask

  // stop offering, wait for every verdict, then let the pipeline settle
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write both geometry registers while the block is idle
  task automatic set_frame(input logic [FRAME_WIDTH_W-1:0] w,
                           input logic [FRAME_HEIGHT_W-1:0] h);
    int unsigned old_w;
    wait_idle();
    old_w = eff_width();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_FRAME_WIDTH;
    cfg_wdata_i <= CFG_DATA_W'(w);
    @(posedge clk_i);
    cfg_addr_i  <= CFG_FRAME_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    width_reg  = w;
    height_reg = h;
    if (eff_width() > old_w) restart_needed = 1'b1;
  endtask

  // one whole frame at a given (possibly out-of-range) geometry
  task automatic run_frame_at(input int unsigned w, input int unsigned h);
    set_frame(FRAME_WIDTH_W'(w), FRAME_HEIGHT_W'(h));
    send_run(eff_width() * eff_height(), 1'b1, 0);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset size 640 wide, counters start at (0,0) without a frame start;
  // the first few pixels of row 2 show that rows wrap at 640
  task automatic test_reset_geometry();
    label_style = LABELS_BLOCKS;
    send_run(2 * 640 + 5, 1'b0, 0);
  endtask

  // extreme labels on 3x3 frames; later frames rely on the end-of-frame wrap
  task automatic test_label_extremes();
    int unsigned i;
    set_frame(3, 3);
    for (i = 0; i < 36; i++) begin
      send_pixel(EXTREME_LABELS[(35 - i) * 8 +: 8], i == 0);
    end
  endtask

  // frame start in the middle of a row restarts the counters
  task automatic test_frame_restart();
    label_style = LABELS_RUNS;
    set_frame(4, 4);
    send_run(6, 1'b1, 0);
    send_run(16, 1'b1, 0);
    send_run(16, 1'b0, 0);
  endtask

  // size changes in mid-frame: shrunk width and height wrap at once
  task automatic test_geometry_change();
    label_style = LABELS_RUNS;
    set_frame(8, 8);
    send_run(8 * 3 + 5, 1'b1, 0);
    set_frame(5, 8);   // column past the new end
    send_run(12, 1'b0, 0);
    set_frame(5, 4);   // row past the new end
    send_run(23, 1'b0, 0);
    set_frame(7, 6);   // grown width forces a fresh frame
    send_run(52, 1'b0, 0);
  endtask

  // register values below the range clamp to the smallest width or height
  task automatic test_geometry_clamp();
    label_style = LABELS_BLOCKS;
    run_frame_at(0, 5);
    run_frame_at(2, 1);
    run_frame_at(1, 0);
  endtask

  // receiver holds off while the sender keeps offering, then a full drain
  task automatic test_output_hold();
    label_style = LABELS_RUNS;
    set_frame(6, 5);
    gaps_on = 1'b0;
    ready_mode = READY_ALWAYS;
    hold_req = HOLD_CYCLES;
    send_run(60, 1'b1, 0);
    wait_idle();
    gaps_on = 1'b1;
    ready_mode = READY_RANDOM;
  endtask

  // random geometries, labels and flow control; most runs are whole frames
  task automatic test_random_frames();
    int unsigned start_count;
    int unsigned w;
    int unsigned h;
    int unsigned area;
    int unsigned left;
    int unsigned n;
    start_count = labels_sent;
    while (labels_sent - start_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(15, 40);
        h = $urandom_range(3, 8);
      end else begin
        w = $urandom_range(0, 12);
        h = $urandom_range(0, 10);
      end
      if ($urandom_range(0, 5) != 0) set_frame(FRAME_WIDTH_W'(w), FRAME_HEIGHT_W'(h));
      label_style = label_style_e'($urandom_range(0, 2));
      palette[0] = LABEL_W'($urandom);
      palette[1] = LABEL_W'($urandom);
      palette[2] = LABEL_W'($urandom);
      ready_mode = ready_mode_e'($urandom_range(0, 2));
      ready_pattern = 16'($urandom) | 16'h0001;
      gaps_on = ($urandom_range(0, 4) != 0);
      area = eff_width() * eff_height();
      left = RANDOM_ITEMS - (labels_sent - start_count);
      if ($urandom_range(0, 3) != 0) begin
        n = area * $urandom_range(1, 2);
        if (n > left) n = left;
        send_run(n, $urandom_range(0, 3) != 0, 0);
      end else begin
        // broken frames: random length and stray frame starts
        n = $urandom_range(1, 2 * area);
        if (n > left) n = left;
        send_run(n, $urandom_range(0, 1) != 0, 40);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: own stall pattern, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (hold_req) @(posedge clk_i);
        hold_req = 0;
      end
      case (ready_mode)
        READY_ALWAYS: m_axis_tready_i <= 1'b1;
        READY_PATTERN: begin
          m_axis_tready_i <= ready_pattern[ready_phase];
          ready_phase = (ready_phase + 1) % 16;
        end
        default: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every accepted output word against the oldest verdict
  // ---------------------------------------------------------------------------
  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: pixel (%0d,%0d) %s expected %0d actual %0d",
                 $time, want_v.row, want_v.col, field, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      // unpack the output word, row in the lowest bits
      got_v.row        = m_axis_tdata_o[ROW_W-1:0];
      got_v.col        = m_axis_tdata_o[ROW_W +: COL_W];
      got_v.mask       = m_axis_tdata_o[ROW_W+COL_W +: MASK_W];
      got_v.boundary   = m_axis_tdata_o[ROW_W+COL_W+MASK_W];
      got_v.frame_last = m_axis_tlast_o;
      if (got_v.frame_last) frames_closed++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: expected no word, actual tdata %h tlast %b",
                   $time, m_axis_tdata_o, m_axis_tlast_o);
        end
      end else begin
        want_v = verdict_q.pop_front();
        verdicts_checked++;
        check_field("row", 32'(want_v.row), 32'(got_v.row));
        check_field("col", 32'(want_v.col), 32'(got_v.col));
        check_field("mask", 32'(want_v.mask), 32'(got_v.mask));
        check_field("boundary", 32'(want_v.boundary), 32'(got_v.boundary));
        check_field("frame_last", 32'(want_v.frame_last), 32'(got_v.frame_last));
      end
    end
  end

  // watchdog: too long without a word moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d verdicts pending",
               $time, quiet_cycles, verdict_q.size());
      $display("[label_boundary_detector_3x3] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // predictor starts from the reset state of the block
    width_reg  = 640;
    height_reg = 480;
    for (int i = 0; i < LINE_MAX; i++) begin
      row_above[i]  = '0;
      row_above2[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) window[i][j] = '0;
    end
    col_pos = 0;
    row_pos = 0;
    burst_left = 0;
    gaps_on = 1'b1;
    restart_needed = 1'b0;
    ready_mode = READY_RANDOM;
    ready_pattern = 16'hB5E7;
    ready_phase = 0;
    hold_req = 0;
    label_style = LABELS_RUNS;
    palette[0] = 8'h00;
    palette[1] = 8'hFF;
    palette[2] = 8'h5A;
    last_label = 8'h00;
    labels_sent = 0;
    verdicts_checked = 0;
    frames_closed = 0;
    mismatches = 0;
    quiet_cycles = 0;

    // all inputs known from time zero, reset asserted before the tests
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_addr_i      <= CFG_FRAME_WIDTH;
    cfg_wdata_i     <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_geometry();
    test_label_extremes();
    test_frame_restart();
    test_geometry_change();
    test_geometry_clamp();
    test_output_hold();
    test_random_frames();
    wait_idle();

    $display("%0d labels sent, %0d verdicts checked, %0d frames closed by tlast",
             labels_sent, verdicts_checked, frames_closed);
    $display("reset size of 640 wide, small and clamped frames, restarts, %s",
             "mid-frame resizing, input gaps, output stalls and a long hold-off");
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("[label_boundary_detector_3x3] OK");
    end else begin
      $display("[label_boundary_detector_3x3] ERROR");
    end
    $finish;
  end

endmodule
